>>> hdl/ptd_pkg.sv
package ptd_pkg;

  localparam int unsigned NUM_TASKS_DEF = 8;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned TASK_IDX_W = 6;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OCCUPIED = 2'd2,
    ST_NOTASK   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_WALK  = 2'd1,
    S_FLUSH = 2'd2
  } state_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [7:0]       slot;
    logic [CNT_W-1:0] period;
    logic [7:0]       first_delay;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  fired;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  last;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [2:0]       op;
    logic [7:0]       slot;
    logic [CNT_W-1:0] period;
    logic [7:0]       first_delay;
  } cell_cmd_t;

  typedef struct packed {
    logic start;
    logic adv;
  } walk_t;

endpackage

>>> hdl/ptd_cell.sv
module ptd_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  ptd_pkg::cell_cmd_t  ccmd,
  input  ptd_pkg::walk_t      walk,
  input  logic                tok_in,
  output logic                tok_out,
  output logic                fire,
  output logic                present
);

  logic                      running;
  logic                      tok;
  logic [ptd_pkg::CNT_W-1:0] period;
  logic [ptd_pkg::CNT_W-1:0] count;
  logic                      hit;
  logic                      active;

  assign hit     = ccmd.en && (ccmd.slot == 8'(INDEX));
  assign active  = tok && present && running;
  assign fire    = active && (count == '0);
  assign tok_out = tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      running <= 1'b0;
      tok     <= 1'b0;
    end else begin
      if (walk.adv) begin
        tok <= tok_in;
      end
      if (hit) begin
        case (ccmd.op)
          ptd_pkg::CMD_CREATE: begin
            present <= 1'b1;
            running <= 1'b1;
          end
          ptd_pkg::CMD_DELETE: begin
            present <= 1'b0;
            running <= 1'b0;
          end
          ptd_pkg::CMD_SUSPEND: begin
            running <= 1'b0;
          end
          ptd_pkg::CMD_RESUME: begin
            running <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && (ccmd.op == ptd_pkg::CMD_CREATE)) begin
      period <= ccmd.period;
      count  <= ptd_pkg::CNT_W'(ccmd.first_delay);
    end else if (walk.adv && active) begin
      count <= (count == '0) ? period : count - ptd_pkg::CNT_W'(1);
    end
  end

endmodule

>>> hdl/ptd_ctrl.sv
module ptd_ctrl #(
  parameter int unsigned NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ptd_pkg::req_t       req,
  output logic                res_valid,
  input  logic                res_ready,
  output ptd_pkg::rsp_t       res,
  input  logic                fire_any,
  input  logic [NUM_TASKS-1:0] present_vec,
  output ptd_pkg::cell_cmd_t  ccmd,
  output ptd_pkg::walk_t      walk
);

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned PAD   = 1 << IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  ptd_pkg::state_e   state;
  ptd_pkg::state_e   state_next;
  ptd_pkg::status_e  status;
  logic [PAD-1:0]    pres_pad;
  logic              in_range;
  logic              present_sel;
  logic              accept;
  logic              is_tick;
  logic              out_free;
  logic              can;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  pend_idx;
  logic              pend_valid;

  assign pres_pad    = PAD'(present_vec);
  assign in_range    = req.slot < 8'(NUM_TASKS);
  assign present_sel = in_range && pres_pad[req.slot[IDX_W-1:0]];
  assign accept      = req_valid && req_ready;
  assign is_tick     = req.cmd == ptd_pkg::CMD_TICK;
  assign out_free    = !res_valid || res_ready;
  assign can         = !fire_any || !pend_valid || out_free;

  always_comb begin
    status = ptd_pkg::ST_OK;
    case (req.cmd)
      ptd_pkg::CMD_CREATE: begin
        if (!in_range) begin
          status = ptd_pkg::ST_RANGE;
        end else if (present_sel) begin
          status = ptd_pkg::ST_OCCUPIED;
        end
      end
      ptd_pkg::CMD_DELETE, ptd_pkg::CMD_SUSPEND, ptd_pkg::CMD_RESUME: begin
        if (!present_sel) begin
          status = ptd_pkg::ST_NOTASK;
        end
      end
      default: begin
        status = ptd_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    ccmd.en          = accept && !is_tick && (status == ptd_pkg::ST_OK);
    ccmd.op          = req.cmd;
    ccmd.slot        = req.slot;
    ccmd.period      = req.period;
    ccmd.first_delay = req.first_delay;
  end

  always_comb begin
    state_next = state;
    case (state)
      ptd_pkg::S_IDLE: begin
        if (accept && is_tick) begin
          state_next = ptd_pkg::S_WALK;
        end
      end
      ptd_pkg::S_WALK: begin
        if (can && (idx == LAST_IDX)) begin
          state_next = ptd_pkg::S_FLUSH;
        end
      end
      ptd_pkg::S_FLUSH: begin
        if (out_free) begin
          state_next = ptd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    walk.start = 1'b0;
    walk.adv   = 1'b0;
    case (state)
      ptd_pkg::S_IDLE: begin
        req_ready  = !res_valid;
        walk.start = accept && is_tick;
        walk.adv   = accept && is_tick;
      end
      ptd_pkg::S_WALK: begin
        walk.adv = can;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptd_pkg::S_IDLE;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (accept && !is_tick) begin
        res_valid <= 1'b1;
      end
      if ((state == ptd_pkg::S_WALK) && walk.adv && fire_any) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          res_valid <= 1'b1;
        end
      end
      if ((state == ptd_pkg::S_FLUSH) && out_free) begin
        res_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (walk.start) begin
      idx <= '0;
    end else if ((state == ptd_pkg::S_WALK) && walk.adv) begin
      idx <= idx + IDX_W'(1);
    end
    if (accept && !is_tick) begin
      res <= '{status: status, fired: 1'b0, task_index: '0, last: 1'b1};
    end
    if ((state == ptd_pkg::S_WALK) && walk.adv && fire_any) begin
      pend_idx <= idx;
      if (pend_valid) begin
        res <= '{status: ptd_pkg::ST_OK, fired: 1'b1,
                 task_index: ptd_pkg::TASK_IDX_W'(pend_idx), last: 1'b0};
      end
    end
    if ((state == ptd_pkg::S_FLUSH) && out_free) begin
      if (pend_valid) begin
        res <= '{status: ptd_pkg::ST_OK, fired: 1'b1,
                 task_index: ptd_pkg::TASK_IDX_W'(pend_idx), last: 1'b1};
      end else begin
        res <= '{status: ptd_pkg::ST_OK, fired: 1'b0, task_index: '0, last: 1'b1};
      end
    end
  end

endmodule

>>> hdl/periodic_task_dispatcher.sv
// A command gives its single result in the cycle after it is taken; the next request is
// taken once that result has been collected.
// A tick passes a token down the row of slot cells, one cell per cycle while fire results
// are not held back at the output, then flushes the last result; the next request is
// taken once that result has been collected.
// Synchronous reset clears every slot's present and running bits and empties the output.
module periodic_task_dispatcher #(
  parameter int unsigned NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ptd_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output ptd_pkg::rsp_t res
);

  ptd_pkg::cell_cmd_t   ccmd;
  ptd_pkg::walk_t       walk;
  logic [NUM_TASKS:0]   tok_chain;
  logic [NUM_TASKS-1:0] fire_vec;
  logic [NUM_TASKS-1:0] present_vec;

  assign tok_chain[0] = walk.start;

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    ptd_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ccmd    (ccmd),
      .walk    (walk),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .fire    (fire_vec[i]),
      .present (present_vec[i])
    );
  end

  ptd_ctrl #(
    .NUM_TASKS (NUM_TASKS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .fire_any    ((|fire_vec) || (tok_chain[NUM_TASKS] && 1'b0)),
    .present_vec (present_vec),
    .ccmd        (ccmd),
    .walk        (walk)
  );

endmodule

>>> hdl/ptd_checker.sv
module ptd_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ptd_pkg::req_t req,
  input logic          res_valid,
  input logic          res_ready,
  input ptd_pkg::rsp_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("Result changed or dropped while stalled.");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("New request taken while the previous one is still in work.");

  a_cmd_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.cmd != ptd_pkg::CMD_TICK)
    |=> res_valid && res.last && !res.fired)
    else $error("Command did not give a single final result.");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.fired |-> res.task_index == '0 && res.last)
    else $error("Non-fire result carries a task index or is not final.");

  a_error_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != ptd_pkg::ST_OK) |-> !res.fired)
    else $error("Fire result reports an error status.");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (.*);
